FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block (qat_checker.sv).
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QAT_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("qat: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QAT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("qat: next-cycle check failed");

`endif

FILE: design/qat_pkg.sv
// Types, constants and helper functions of the quoted argument tokenizer.
// No dependencies; imported by every module of the block.
package qat_pkg;

  localparam int CHAR_W       = 16;
  localparam int REP_W        = 16;
  localparam int RUN_BITS_DEF = 16;
  localparam int RES_MAX      = 3;   // results one request can cause
  localparam int BQ_DEPTH     = 2;   // result batches held on the output side

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [REP_W-1:0]  rep_t;

  localparam char_t CH_NUL   = 16'h0000;
  localparam char_t CH_SLASH = 16'h005C;
  localparam char_t CH_HASH  = 16'h0023;
  localparam char_t CH_DQ    = 16'h0022;
  localparam char_t CH_SQ    = 16'h0027;

  typedef enum logic {
    MODE_CHAR = 1'b0,
    MODE_EOL  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    KIND_APPEND    = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NUL    = 2'd1,
    ST_UNTERM = 2'd2
  } line_status_t;

  typedef struct packed {
    mode_t mode;
    char_t char_code;
  } in_item_t;

  typedef struct packed {
    kind_t        kind;
    char_t        char_value;
    rep_t         repeat_res;
    line_status_t line_status;
    logic         last;
  } out_item_t;

  // All results of one request, packed from entry 0, cnt of them valid.
  typedef struct packed {
    logic [1:0]                cnt;
    out_item_t [RES_MAX-1:0]   item;
  } res_batch_t;

  // Unicode space set
  function automatic logic is_space(input char_t c);
    return c inside {16'h0020, [16'h0009:16'h000D], 16'h0085, 16'h00A0, 16'h1680,
                     [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F,
                     16'h3000};
  endfunction

endpackage

FILE: design/qat_core.sv
// Tokenizer state registers and the single-pass decode of one request.
// Depends on qat_pkg. Produces the packed result batch for qat_outq.
module qat_core #(
  parameter int RUN_BITS = qat_pkg::RUN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  qat_pkg::in_item_t   item,
  output qat_pkg::res_batch_t batch
);
  import qat_pkg::*;

  localparam int CNT_W = (RUN_BITS > CHAR_W) ? CHAR_W : RUN_BITS;

  logic             inq_r, inq_nxt;
  logic             qsingle_r, qsingle_nxt;
  logic             tok_r, tok_nxt;
  logic             skip_r, skip_nxt;
  logic             fail_r, fail_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;

  char_t        c, qc;
  logic         run_some, is_q, syn, do_plain;
  logic         a_vld, b_vld, c_vld;
  rep_t         a_rep;
  kind_t        b_kind;
  char_t        b_char;
  line_status_t st;
  out_item_t    it_a, it_b, it_c;

  always_comb begin
    inq_nxt     = inq_r;
    qsingle_nxt = qsingle_r;
    tok_nxt     = tok_r;
    skip_nxt    = skip_r;
    fail_nxt    = fail_r;
    run_nxt     = run_r;

    c        = item.char_code;
    qc       = qsingle_r ? CH_SQ : CH_DQ;
    run_some = (run_r != '0);
    is_q     = (c == CH_DQ) || (c == CH_SQ);
    syn      = inq_r ? (c == qc) : is_q;
    do_plain = 1'b0;

    a_vld  = 1'b0;
    a_rep  = '0;
    b_vld  = 1'b0;
    b_kind = KIND_APPEND;
    b_char = '0;
    c_vld  = 1'b0;
    st     = ST_OK;

    if (item.mode == MODE_EOL) begin
      a_vld = run_some;
      a_rep = REP_W'(run_r);
      if (fail_r) begin
        st = ST_NUL;
      end else if (inq_r) begin
        st = ST_UNTERM;
      end else begin
        st = ST_OK;
      end
      if ((st == ST_OK) && tok_r) begin
        b_vld  = 1'b1;
        b_kind = KIND_TOKEN_END;
      end
      c_vld       = 1'b1;
      inq_nxt     = 1'b0;
      qsingle_nxt = 1'b0;
      tok_nxt     = 1'b0;
      skip_nxt    = 1'b0;
      fail_nxt    = 1'b0;
      run_nxt     = '0;
    end else if (fail_r || skip_r) begin
      // rest of the line is dropped
    end else if (c == CH_NUL) begin
      a_vld    = run_some;
      a_rep    = REP_W'(run_r);
      run_nxt  = '0;
      fail_nxt = 1'b1;
    end else if (c == CH_SLASH) begin
      if (run_r != '1) begin
        run_nxt = run_r + CNT_W'(1);
      end
      tok_nxt = 1'b1;
    end else if (run_some && syn) begin
      // escaped or live quote: half the run goes out as literal backslashes
      run_nxt = '0;
      a_vld   = ((run_r >> 1) != '0);
      a_rep   = REP_W'(run_r >> 1);
      if (run_r[0]) begin
        b_vld  = 1'b1;
        b_char = c;
      end else if (inq_r) begin
        inq_nxt = 1'b0;
      end else begin
        inq_nxt     = 1'b1;
        qsingle_nxt = (c == CH_SQ);
      end
    end else begin
      a_vld    = run_some;
      a_rep    = REP_W'(run_r);
      run_nxt  = '0;
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (inq_r) begin
        if (c == qc) begin
          inq_nxt = 1'b0;
        end else begin
          b_vld  = 1'b1;
          b_char = c;
        end
      end else if ((c == CH_HASH) && !tok_r) begin
        skip_nxt = 1'b1;
      end else if (is_q) begin
        inq_nxt     = 1'b1;
        qsingle_nxt = (c == CH_SQ);
        tok_nxt     = 1'b1;
      end else if (is_space(c)) begin
        if (tok_r) begin
          b_vld   = 1'b1;
          b_kind  = KIND_TOKEN_END;
          tok_nxt = 1'b0;
        end
      end else begin
        b_vld   = 1'b1;
        b_char  = c;
        tok_nxt = 1'b1;
      end
    end

    it_a = '{kind: KIND_APPEND, char_value: CH_SLASH, repeat_res: a_rep,
             line_status: ST_OK, last: !b_vld && !c_vld};
    it_b = '{kind: b_kind, char_value: b_char,
             repeat_res: (b_kind == KIND_APPEND) ? rep_t'(1) : '0,
             line_status: ST_OK, last: !c_vld};
    it_c = '{kind: KIND_LINE_END, char_value: '0, repeat_res: '0,
             line_status: st, last: 1'b1};

    batch.item[0] = a_vld ? it_a : (b_vld ? it_b : it_c);
    batch.item[1] = (a_vld && b_vld) ? it_b : it_c;
    batch.item[2] = it_c;
    batch.cnt     = 2'(a_vld) + 2'(b_vld) + 2'(c_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r     <= 1'b0;
      qsingle_r <= 1'b0;
      tok_r     <= 1'b0;
      skip_r    <= 1'b0;
      fail_r    <= 1'b0;
      run_r     <= '0;
    end else if (take) begin
      inq_r     <= inq_nxt;
      qsingle_r <= qsingle_nxt;
      tok_r     <= tok_nxt;
      skip_r    <= skip_nxt;
      fail_r    <= fail_nxt;
      run_r     <= run_nxt;
    end
  end

endmodule

FILE: design/qat_outq.sv
// Result batch queue: holds decoded batches and hands out their results one at a time.
// Depends on qat_pkg.
module qat_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qat_pkg::res_batch_t batch,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output qat_pkg::out_item_t  out_data
);
  import qat_pkg::*;

  localparam int PTR_W  = (BQ_DEPTH > 1) ? $clog2(BQ_DEPTH) : 1;
  localparam int FILL_W = $clog2(BQ_DEPTH + 1);
  localparam int IDX_W  = $clog2(RES_MAX);

  res_batch_t        bq_r [BQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pop_item, pop_batch;

  assign out_valid = (fill_r != '0);
  assign out_data  = bq_r[rd_ptr_r].item[idx_r];
  assign room      = (fill_r != FILL_W'(BQ_DEPTH));
  assign pop_item  = out_valid && out_ready;
  assign pop_batch = pop_item && out_data.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    idx_nxt    = idx_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(BQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_batch) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(BQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      idx_nxt    = '0;
    end else if (pop_item) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    fill_nxt = fill_r + FILL_W'(push) - FILL_W'(pop_batch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      idx_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      bq_r[wr_ptr_r] <= batch;
    end
  end

endmodule

FILE: design/quoted_argument_tokenizer.sv
// Top level of the quoted argument tokenizer.
// Depends on qat_pkg, qat_core and qat_outq.
//
// Usage:
//   in_*  : one request per character (mode char) or end of line (mode eol).
//   out_* : results in order: append (char_value x repeat_res), token end,
//           line end with status; last marks the final result of a request.
// Results: the batch of an accepted request is registered in the queue
//   before its first result shows; a request with k results gives k transfers.
//   Requests that cause no result leave nothing behind.
// Throughput: one request per cycle while each causes at most one result
//   and the receiver keeps out_ready high. The queue holds two result
//   batches, so in_ready depends only on registered fill, not on out_ready.
// Reset: synchronous on rst_n low; tokenizer state is cleared, the queue is
//   emptied and out_valid drops.
// Stall: with out_ready low the current result holds; input is still taken
//   until both batch slots are full, then in_ready drops.
module quoted_argument_tokenizer #(
  parameter int RUN_BITS = qat_pkg::RUN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qat_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qat_pkg::out_item_t out_data
);
  import qat_pkg::*;

  logic       take;
  logic       push;
  res_batch_t batch;

  // decode runs against state in the same cycle the request is taken
  assign take = in_valid && in_ready;
  assign push = take && (batch.cnt != '0);

  qat_core #(
    .RUN_BITS (RUN_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .batch (batch)
  );

  qat_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .batch     (batch),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/qat_checker.sv
// Port-level checks for the quoted argument tokenizer, bound to the top level.
// Depends on qat_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qat_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input qat_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input qat_pkg::out_item_t out_data
);
  import qat_pkg::*;

  // stalled result holds
  `QAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // line end closes the request's results
  `QAT_ASSERT_NOW(a_line_last, clk, rst_n, out_valid && (out_data.kind == KIND_LINE_END), out_data.last)

  // appends always carry a nonzero count
  `QAT_ASSERT_NOW(a_app_rep, clk, rst_n, out_valid && (out_data.kind == KIND_APPEND), out_data.repeat_res != '0)

  // status is only reported on a line end
  `QAT_ASSERT_NOW(a_status_kind, clk, rst_n, out_valid && (out_data.kind != KIND_LINE_END), out_data.line_status == ST_OK)

  // an end-of-line request always leaves a result behind
  `QAT_ASSERT_NEXT(a_eol_out, clk, rst_n, in_valid && in_ready && (in_data.mode == MODE_EOL), out_valid)

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
